// ===== hdl/tfc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants of the TCP flow counter.
// ----------------------------------------------------------------------------
package tfc_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'h06;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_HIT   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_key;

    // one job handed from the parser to the table engine
    typedef struct packed {
        logic        rd;       // slot read-out
        logic        ok;       // frame passed the header checks
        logic [7:0]  rslot;
        logic [15:0] wlen;
        t_key        key;
    } t_job;

endpackage

// ===== hdl/tcp_flow_counter_core.sv =====
// ----------------------------------------------------------------------------
// tcp_flow_counter_core
// Per-flow packet and byte counter for IPv4/TCP frames.
// ----------------------------------------------------------------------------
// Input queue side: push with full low moves one transaction, a frame byte
// (op 0) or a slot read request (op 1). Frame bytes may stream one per cycle while full stays low.
// Result queue side: while empty is low the oldest result is on the o_ ports;
// pop takes it. One result per last byte and per read request.
// The parser registers each job into a four-deep job queue. The table
// engine scans used slots in turn, each with a registered memory read
// then a compare.
// The engine holds one result and takes no new job while it waits unpopped.
// full rises when the job queue could overflow; a stalled result side backs
// up into the job queue and then into full.
// Reset empties both queues and the flow table at once (fill count only,
// no clearing pass).
// ----------------------------------------------------------------------------
module tcp_flow_counter_core #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [15:0] i_wire_len,
    input  logic [7:0]  i_read_slot,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot,
    output logic        o_entry_valid,
    output logic [31:0] o_src_ip,
    output logic [31:0] o_dst_ip,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic [63:0] o_pkt_count,
    output logic [63:0] o_byte_count
);
    localparam int QD = 4;

    logic          acc;
    logic          pj_valid;
    tfc_pkg::t_job pj;
    logic          q_empty, q_pop;
    logic [$clog2(QD+1)-1:0] q_cnt;
    tfc_pkg::t_job q_job;
    logic          res_valid;
    tfc_pkg::t_key okey;

    // leave room for the job still in the parser register
    assign full = (q_cnt >= ($clog2(QD+1))'(QD - 1));
    assign acc  = push && !full;

    tfc_parser u_parser (
        .i_clk, .i_rst_n,
        .i_valid(acc), .i_op, .i_data_byte, .i_last, .i_wire_len, .i_read_slot,
        .o_job_valid(pj_valid), .o_job(pj)
    );

    tfc_jobq #(.DEPTH(QD)) u_jobq (
        .i_clk, .i_rst_n,
        .i_push(pj_valid), .i_job(pj), .i_pop(q_pop),
        .o_empty(q_empty), .o_count(q_cnt), .o_job(q_job)
    );

    tfc_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
        .i_clk, .i_rst_n,
        .i_job_valid(!q_empty), .i_job(q_job), .o_job_pop(q_pop),
        .i_res_ready(pop), .o_res_valid(res_valid),
        .o_kind, .o_status, .o_slot, .o_entry_valid, .o_key(okey),
        .o_pkts(o_pkt_count), .o_bytes(o_byte_count)
    );

    assign empty      = !res_valid;
    assign o_src_ip   = okey.sip;
    assign o_dst_ip   = okey.dip;
    assign o_src_port = okey.sport;
    assign o_dst_port = okey.dport;

`ifndef SYNTH
    a_no_q_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pj_valid |-> q_cnt < ($clog2(QD+1))'(QD)) else $error("job queue overflow");
    a_counted_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_kind && (o_status == tfc_pkg::ST_NEW || o_status == tfc_pkg::ST_HIT))
        |-> o_entry_valid && o_pkt_count != 64'd0) else $error("counted verdict bad");
    a_new_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_kind && o_status == tfc_pkg::ST_NEW) |-> o_pkt_count == 64'd1)
        else $error("new flow count not one");
`endif

endmodule

// ===== hdl/tfc_parser.sv =====
// ----------------------------------------------------------------------------
// tfc_parser
// Front end: walks the frame bytes, captures the header fields and emits one
// job per last byte or per read request.
// ----------------------------------------------------------------------------
module tfc_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_op,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    input  logic [15:0]   i_wire_len,
    input  logic [7:0]    i_read_slot,
    output logic          o_job_valid,
    output tfc_pkg::t_job o_job
);

    logic [15:0]   r_off;
    logic [15:0]   r_etype;
    logic [3:0]    r_ihl;
    logic [7:0]    r_proto;
    tfc_pkg::t_key r_key;

    logic [15:0]   n_etype;
    logic [3:0]    n_ihl;
    logic [7:0]    n_proto;
    tfc_pkg::t_key n_key;
    logic [16:0]   tcp_at;
    logic [16:0]   captured;
    logic          ok;

    assign tcp_at   = 17'd14 + {11'd0, r_ihl, 2'b00};
    assign captured = {1'b0, r_off} + 17'd1;

    always_comb begin
        n_etype = r_etype;
        n_ihl   = r_ihl;
        n_proto = r_proto;
        n_key   = r_key;
        if (r_off == 16'd12) n_etype[15:8] = i_data_byte;
        else if (r_off == 16'd13) n_etype[7:0] = i_data_byte;
        else if (r_off == 16'd14) n_ihl = i_data_byte[3:0];
        else if (r_off == 16'd23) n_proto = i_data_byte;
        else if (r_off >= 16'd26 && r_off <= 16'd29)
            n_key.sip = {r_key.sip[23:0], i_data_byte};
        else if (r_off >= 16'd30 && r_off <= 16'd33)
            n_key.dip = {r_key.dip[23:0], i_data_byte};
        if (r_ihl >= 4'd5 && r_off >= 16'd34) begin
            if ({1'b0, r_off} == tcp_at || {1'b0, r_off} == tcp_at + 17'd1)
                n_key.sport = {r_key.sport[7:0], i_data_byte};
            else if ({1'b0, r_off} == tcp_at + 17'd2 || {1'b0, r_off} == tcp_at + 17'd3)
                n_key.dport = {r_key.dport[7:0], i_data_byte};
        end
    end

    // checks take the header state including this byte
    assign ok = (n_etype == tfc_pkg::ETHERTYPE_IPV4) && (n_proto == tfc_pkg::PROTO_TCP)
              && (n_ihl >= 4'd5)
              && (captured >= 17'd34 + {11'd0, n_ihl, 2'b00});

    always_ff @(posedge i_clk) begin
        o_job.rd    <= i_op;
        o_job.ok    <= ok;
        o_job.rslot <= i_read_slot;
        o_job.wlen  <= i_wire_len;
        o_job.key   <= n_key;
        if (!i_rst_n) begin
            r_off       <= '0;
            r_etype     <= '0;
            r_ihl       <= '0;
            r_proto     <= '0;
            r_key       <= '0;
            o_job_valid <= 1'b0;
        end else begin
            o_job_valid <= i_valid && (i_op || i_last);
            if (i_valid && !i_op) begin
                if (i_last) begin
                    r_off   <= '0;
                    r_etype <= '0;
                    r_ihl   <= '0;
                    r_proto <= '0;
                    r_key   <= '0;
                end else begin
                    if (r_off != 16'hFFFF) r_off <= r_off + 16'd1;
                    r_etype <= n_etype;
                    r_ihl   <= n_ihl;
                    r_proto <= n_proto;
                    r_key   <= n_key;
                end
            end
        end
    end

endmodule

// ===== hdl/tfc_jobq.sv =====
// ----------------------------------------------------------------------------
// tfc_jobq
// Small FIFO of jobs between the parser and the table engine.
// ----------------------------------------------------------------------------
module tfc_jobq #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tfc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output tfc_pkg::t_job o_job
);
    localparam int AW = $clog2(DEPTH);

    tfc_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [$clog2(DEPTH+1)-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

endmodule

// ===== hdl/tfc_table.sv =====
// ----------------------------------------------------------------------------
// tfc_table
// Back end: flow table. Scans used slots in turn (registered read, then compare) for a key match,
// then updates the counters and holds the result in one output register.
// ----------------------------------------------------------------------------
module tfc_table #(
    parameter int ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  tfc_pkg::t_job i_job,
    output logic          o_job_pop,
    input  logic          i_res_ready,
    output logic          o_res_valid,
    output logic          o_kind,
    output logic [1:0]    o_status,
    output logic [7:0]    o_slot,
    output logic          o_entry_valid,
    output tfc_pkg::t_key o_key,
    output logic [63:0]   o_pkts,
    output logic [63:0]   o_bytes
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_SCAN, S_CMP, S_UPD, S_OUT} t_state;

    tfc_pkg::t_key r_keys [ENTRIES];
    logic [63:0]   r_pk   [ENTRIES];
    logic [63:0]   r_by   [ENTRIES];
    logic [CW-1:0] r_fill;   // used slots are always 0..fill-1

    t_state        r_state;
    tfc_pkg::t_job r_job;
    logic [AW-1:0] r_idx;
    tfc_pkg::t_key r_rkey;
    logic [63:0]   r_rpk, r_rby;

    logic          r_ov;
    logic          r_okind, r_oev;
    logic [1:0]    r_ost;
    logic [7:0]    r_oslot;
    tfc_pkg::t_key r_okey;
    logic [63:0]   r_opk, r_oby;

    logic          take;

    // a new job only once the held result is gone or leaves at this edge
    assign take          = (r_state == S_IDLE) && i_job_valid && (!r_ov || i_res_ready);
    assign o_job_pop     = take;
    assign o_res_valid   = r_ov;
    assign o_kind        = r_okind;
    assign o_status      = r_ost;
    assign o_slot        = r_oslot;
    assign o_entry_valid = r_oev;
    assign o_key         = r_okey;
    assign o_pkts        = r_opk;
    assign o_bytes       = r_oby;

    always_ff @(posedge i_clk) begin
        r_rkey <= r_keys[r_idx];
        r_rpk  <= r_pk[r_idx];
        r_rby  <= r_by[r_idx];
        if (r_state == S_UPD) begin
            if (r_ost == tfc_pkg::ST_NEW) begin
                r_keys[r_idx] <= r_job.key;
                r_pk[r_idx]   <= 64'd1;
                r_by[r_idx]   <= {48'd0, r_job.wlen};
            end else begin
                r_pk[r_idx]   <= r_rpk + 64'd1;
                r_by[r_idx]   <= r_rby + {48'd0, r_job.wlen};
            end
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (r_ov && i_res_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_job <= i_job;
                        r_idx <= '0;
                        if (i_job.rd) begin
                            r_idx   <= AW'(i_job.rslot);
                            r_oslot <= i_job.rslot;
                            r_oev   <= ({8'd0, i_job.rslot} < 16'(r_fill));
                            r_state <= S_RD;
                        end else if (!i_job.ok) begin
                            r_okind <= 1'b0;
                            r_ost   <= tfc_pkg::ST_NONE;
                            r_oslot <= '0;
                            r_oev   <= 1'b0;
                            r_okey  <= '0;
                            r_opk   <= '0;
                            r_oby   <= '0;
                            r_state <= S_OUT;
                        end else if (r_fill == '0) begin
                            r_ost   <= tfc_pkg::ST_NEW;
                            r_state <= S_UPD;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_RD: begin
                    // wait for the registered read
                    r_state <= S_CMP;
                end
                S_SCAN: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_job.rd) begin
                        r_okind <= 1'b1;
                        r_ost   <= tfc_pkg::ST_NONE;
                        r_okey  <= r_oev ? r_rkey : '0;
                        r_opk   <= r_oev ? r_rpk : '0;
                        r_oby   <= r_oev ? r_rby : '0;
                        r_state <= S_OUT;
                    end else if (r_rkey == r_job.key) begin
                        r_ost   <= tfc_pkg::ST_HIT;
                        r_state <= S_UPD;
                    end else if ({1'b0, r_idx} + 1 < (AW+1)'(r_fill)) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end else if (r_fill < CW'(ENTRIES)) begin
                        r_idx   <= r_fill[AW-1:0];
                        r_ost   <= tfc_pkg::ST_NEW;
                        r_state <= S_UPD;
                    end else begin
                        r_okind <= 1'b0;
                        r_ost   <= tfc_pkg::ST_FULL;
                        r_oslot <= '0;
                        r_oev   <= 1'b0;
                        r_okey  <= r_job.key;
                        r_opk   <= '0;
                        r_oby   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_UPD: begin
                    r_okind <= 1'b0;
                    r_oslot <= 8'(r_idx);
                    r_oev   <= 1'b1;
                    r_okey  <= r_job.key;
                    if (r_ost == tfc_pkg::ST_NEW) begin
                        r_fill        <= r_fill + 1'b1;
                        r_opk         <= 64'd1;
                        r_oby         <= {48'd0, r_job.wlen};
                    end else begin
                        r_opk <= r_rpk + 64'd1;
                        r_oby <= r_rby + {48'd0, r_job.wlen};
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || i_res_ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tcp_flow_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// tcp_flow_counter_core_tb
// Streams Ethernet frames and slot reads into the flow counter core with
// random gaps on both queue sides. Every accepted transaction is run through
// a local model of the parser and flow table, and each popped result is
// compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tcp_flow_counter_core_tb;

    localparam int ENTRIES   = 256;
    localparam int WDOG_MAX  = 20000;
    localparam int OP_BYTE   = 0;
    localparam int OP_READ   = 1;
    localparam int KIND_FRAME = 0;
    localparam int KIND_READ  = 1;

    typedef struct {
        logic        op;
        logic [7:0]  data;
        logic        last;
        logic [15:0] wlen;
        logic [7:0]  rslot;
    } t_item;

    typedef struct {
        logic          kind;
        logic [1:0]    status;
        logic [7:0]    slot;
        logic          ev;
        tfc_pkg::t_key key;
        logic [63:0]   pkts;
        logic [63:0]   bytes;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_op;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic [15:0] i_wire_len;
    logic [7:0]  i_read_slot;
    logic        empty;
    logic        pop;
    logic        o_kind;
    logic [1:0]  o_status;
    logic [7:0]  o_slot;
    logic        o_entry_valid;
    logic [31:0] o_src_ip;
    logic [31:0] o_dst_ip;
    logic [15:0] o_src_port;
    logic [15:0] o_dst_port;
    logic [63:0] o_pkt_count;
    logic [63:0] o_byte_count;

    tcp_flow_counter_core #(.TABLE_ENTRIES(ENTRIES)) u_top (.*);

    t_item         pending_items[$];
    t_verdict      expected_verdicts[$];
    tfc_pkg::t_key flow_pool[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       burst_mode = 0;

    // model state
    logic [15:0]   m_offset;
    logic [15:0]   m_ethertype;
    logic [3:0]    m_ihl;
    logic [7:0]    m_proto;
    tfc_pkg::t_key m_key;
    logic          m_used [ENTRIES];
    tfc_pkg::t_key m_keys [ENTRIES];
    logic [63:0]   m_pkts [ENTRIES];
    logic [63:0]   m_bytes[ENTRIES];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic clear_header();
        m_offset = '0; m_ethertype = '0; m_ihl = '0; m_proto = '0; m_key = '0;
    endtask

    task automatic model_reset();
        clear_header();
        for (int i = 0; i < ENTRIES; i++) begin
            m_used[i] = 0; m_keys[i] = '0; m_pkts[i] = '0; m_bytes[i] = '0;
        end
    endtask

    task automatic predict_item(t_item it);
        t_verdict v;
        int off, tcp_at, hit, free_at;
        bit found;
        v = '{default: '0};
        if (it.op == OP_READ) begin
            v.kind = KIND_READ;
            v.slot = it.rslot;
            if (it.rslot < ENTRIES && m_used[it.rslot]) begin
                v.ev = 1; v.key = m_keys[it.rslot];
                v.pkts = m_pkts[it.rslot]; v.bytes = m_bytes[it.rslot];
            end
            expected_verdicts.push_back(v);
            return;
        end
        off = m_offset;
        tcp_at = 14 + 4 * m_ihl;
        if (off == 12) m_ethertype[15:8] = it.data;
        else if (off == 13) m_ethertype[7:0] = it.data;
        else if (off == 14) m_ihl = it.data[3:0];
        else if (off == 23) m_proto = it.data;
        else if (off >= 26 && off <= 29) m_key.sip = {m_key.sip[23:0], it.data};
        else if (off >= 30 && off <= 33) m_key.dip = {m_key.dip[23:0], it.data};
        if (m_ihl >= 5 && off >= 34) begin
            if (off == tcp_at || off == tcp_at + 1)
                m_key.sport = {m_key.sport[7:0], it.data};
            else if (off == tcp_at + 2 || off == tcp_at + 3)
                m_key.dport = {m_key.dport[7:0], it.data};
        end
        if (m_offset != 16'hFFFF) m_offset = m_offset + 1;
        if (!it.last) return;
        v.kind = KIND_FRAME;
        if (m_ethertype != tfc_pkg::ETHERTYPE_IPV4 || m_proto != tfc_pkg::PROTO_TCP ||
            m_ihl < 5 || off + 1 < 14 + 4 * m_ihl + 20) begin
            expected_verdicts.push_back(v);
            clear_header();
            return;
        end
        found = 0; hit = 0; free_at = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (m_used[i]) begin
                if (!found && m_keys[i] == m_key) begin
                    found = 1; hit = i;
                end
            end else if (free_at < 0) free_at = i;
        end
        v.key = m_key;
        if (!found) begin
            if (free_at < 0) begin
                v.status = tfc_pkg::ST_FULL;
                expected_verdicts.push_back(v);
                clear_header();
                return;
            end
            hit = free_at;
            m_used[hit] = 1; m_keys[hit] = m_key;
            m_pkts[hit] = '0; m_bytes[hit] = '0;
            v.status = tfc_pkg::ST_NEW;
        end else begin
            v.status = tfc_pkg::ST_HIT;
        end
        m_pkts[hit] += 64'd1;
        m_bytes[hit] += {48'd0, it.wlen};
        v.slot = hit[7:0]; v.ev = 1;
        v.pkts = m_pkts[hit]; v.bytes = m_bytes[hit];
        expected_verdicts.push_back(v);
        clear_header();
    endtask

    // ---------------- stimulus builders ----------------
    task automatic add_byte(logic [7:0] b, logic lst, logic [15:0] wl);
        t_item it;
        it = '{op: OP_BYTE, data: b, last: lst, wlen: wl, rslot: $urandom_range(0, 255)};
        pending_items.push_back(it);
    endtask

    task automatic add_read(int slot_idx);
        t_item it;
        it = '{op: OP_READ, data: $urandom_range(0, 255), last: $urandom_range(0, 1),
               wlen: $urandom_range(0, 65535), rslot: slot_idx[7:0]};
        pending_items.push_back(it);
    endtask

    task automatic add_frame(logic [15:0] etype, logic [3:0] ihl, logic [7:0] proto,
                             tfc_pkg::t_key k, int len, logic [15:0] wl, int read_pct);
        int tcp_at;
        logic [7:0] b;
        tcp_at = 14 + 4 * ihl;
        for (int off = 0; off < len; off++) begin
            b = $urandom_range(0, 255);
            if (off == 12) b = etype[15:8];
            else if (off == 13) b = etype[7:0];
            else if (off == 14) b = {b[7:4], ihl};
            else if (off == 23) b = proto;
            else if (off >= 26 && off <= 29) b = k.sip[8 * (29 - off) +: 8];
            else if (off >= 30 && off <= 33) b = k.dip[8 * (33 - off) +: 8];
            else if (off >= 34 && off == tcp_at) b = k.sport[15:8];
            else if (off >= 34 && off == tcp_at + 1) b = k.sport[7:0];
            else if (off >= 34 && off == tcp_at + 2) b = k.dport[15:8];
            else if (off >= 34 && off == tcp_at + 3) b = k.dport[7:0];
            if ($urandom_range(0, 99) < read_pct) add_read($urandom_range(0, 255));
            add_byte(b, off == len - 1, wl);
        end
    endtask

    function automatic tfc_pkg::t_key rand_key();
        tfc_pkg::t_key k;
        k = {$urandom(), $urandom(), $urandom()};
        return k;
    endfunction

    task automatic add_good(tfc_pkg::t_key k, int read_pct);
        logic [3:0] ihl;
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 4'd5;
        add_frame(tfc_pkg::ETHERTYPE_IPV4, ihl, tfc_pkg::PROTO_TCP, k,
                  14 + 4 * ihl + 20 + $urandom_range(0, 10), $urandom(), read_pct);
    endtask

    initial begin
        tfc_pkg::t_key k0;
        int   sel;
        model_reset();
        k0 = rand_key();
        // directed: minimum frame, then repeats, extremes of wire length
        add_frame(tfc_pkg::ETHERTYPE_IPV4, 5, tfc_pkg::PROTO_TCP, k0, 54, 16'd0, 0);
        add_frame(tfc_pkg::ETHERTYPE_IPV4, 5, tfc_pkg::PROTO_TCP, k0, 54, 16'hFFFF, 0);
        add_frame(tfc_pkg::ETHERTYPE_IPV4, 5, tfc_pkg::PROTO_TCP, '1, 60, 16'hFFFF, 0);
        add_frame(tfc_pkg::ETHERTYPE_IPV4, 5, tfc_pkg::PROTO_TCP, '0, 54, 16'd64, 0);
        add_frame(tfc_pkg::ETHERTYPE_IPV4, 15, tfc_pkg::PROTO_TCP, rand_key(), 94,
                  16'd1500, 0);
        add_read(0); add_read(1); add_read(255);
        // rejected: wrong ethertype, wrong protocol, IHL below five, one byte short
        add_frame(16'h86DD, 5, tfc_pkg::PROTO_TCP, rand_key(), 60, 16'd60, 0);
        add_frame(tfc_pkg::ETHERTYPE_IPV4, 5, 8'h11, rand_key(), 60, 16'd60, 0);
        add_frame(tfc_pkg::ETHERTYPE_IPV4, 4, tfc_pkg::PROTO_TCP, rand_key(), 60, 16'd60, 0);
        add_frame(tfc_pkg::ETHERTYPE_IPV4, 5, tfc_pkg::PROTO_TCP, rand_key(), 53, 16'd53, 0);
        add_byte(8'hFF, 1, 16'd1);
        // reads interleaved with a frame being parsed
        add_frame(tfc_pkg::ETHERTYPE_IPV4, 5, tfc_pkg::PROTO_TCP, k0, 64, 16'd64, 30);
        add_read(0);
        for (int i = 0; i < 8; i++) flow_pool.push_back(rand_key());
        // random: mostly well-formed frames, some broken ones, reads and noise
        while (pending_items.size() < 1450) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) add_good(flow_pool[$urandom_range(0, 7)], 3);
            else if (sel < 65) add_good(rand_key(), 3);
            else if (sel < 75) add_frame($urandom_range(0, 1) ? tfc_pkg::ETHERTYPE_IPV4
                                                              : $urandom(),
                                         $urandom_range(0, 15),
                                         $urandom_range(0, 1) ? tfc_pkg::PROTO_TCP
                                                              : $urandom(),
                                         rand_key(), $urandom_range(1, 80), $urandom(), 3);
            else if (sel < 88) add_read($urandom_range(0, 255));
            else add_byte($urandom(), $urandom_range(0, 3) == 0, $urandom());
        end
        // one more known flow, then read back a spread of slots
        add_good(flow_pool[0], 0);
        for (int i = 0; i < 40; i++) add_read($urandom_range(0, 255));
        add_read(255);

        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        wait (pending_items.size() == 0 && expected_verdicts.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ---------------- driver ----------------
    int send_wait = 0;
    int sent_count = 0;
    initial begin
        push = 0; i_op = 0; i_data_byte = 0; i_last = 0; i_wire_len = 0; i_read_slot = 0;
    end

    always @(posedge i_clk) begin
        logic next_push;
        next_push = 0;
        if (!i_rst_n) begin
            next_push = 0;
        end else begin
            if (push && !full) begin
                predict_item(pending_items.pop_front());
                sent_count++;
                if (sent_count % 300 == 0) burst_mode = ~burst_mode;
                send_wait = draw_gap();
            end else if (push) begin
                next_push = 1;
            end
            if (!next_push) begin
                if (send_wait > 0) send_wait--;
                else if (pending_items.size() > 0) begin
                    next_push = 1;
                    i_op <= pending_items[0].op;
                    i_data_byte <= pending_items[0].data;
                    i_last <= pending_items[0].last;
                    i_wire_len <= pending_items[0].wlen;
                    i_read_slot <= pending_items[0].rslot;
                end
            end
        end
        push <= next_push;
    end

    // ---------------- monitor ----------------
    int pop_wait = 0;
    initial pop = 0;

    always @(posedge i_clk) begin
        t_verdict e;
        logic next_pop;
        next_pop = pop;
        if (!i_rst_n) begin
            next_pop = 0;
        end else begin
            if (pop && !empty) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: kind %0d status %0d slot %0d",
                                 o_kind, o_status, o_slot);
                end else begin
                    e = expected_verdicts.pop_front();
                    if (o_kind !== e.kind || o_status !== e.status || o_slot !== e.slot ||
                        o_entry_valid !== e.ev || o_src_ip !== e.key.sip ||
                        o_dst_ip !== e.key.dip || o_src_port !== e.key.sport ||
                        o_dst_port !== e.key.dport || o_pkt_count !== e.pkts ||
                        o_byte_count !== e.bytes) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp: k%0d st%0d sl%0d v%0d %h %h %h %h %h %h",
                                     e.kind, e.status, e.slot, e.ev, e.key.sip, e.key.dip,
                                     e.key.sport, e.key.dport, e.pkts, e.bytes);
                            $display("         got: k%0d st%0d sl%0d v%0d %h %h %h %h %h %h",
                                     o_kind, o_status, o_slot, o_entry_valid, o_src_ip,
                                     o_dst_ip, o_src_port, o_dst_port, o_pkt_count,
                                     o_byte_count);
                        end
                    end
                end
                pop_wait = draw_gap();
                next_pop = 0;
            end
            if (!next_pop) begin
                if (pop_wait > 0) pop_wait--;
                else next_pop = 1;
            end
        end
        pop <= next_pop;
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
